// ----- rtl/core/riex_pkg.sv -----
// ----------------------------------------------------------------------------
// riex_pkg
// Types and constants shared by the instruction execute unit.
// ----------------------------------------------------------------------------
package riex_pkg;

   localparam int unsigned PC_W   = 12;
   localparam int unsigned IMM_W  = 20;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned IDX_W  = 4;
   localparam int unsigned OP_W   = 8;

   localparam int unsigned MEM_DEPTH = 4096;
   localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

   localparam logic signed [WORD_W-1:0] IMM_MAX = 32'sd524287;
   localparam logic signed [WORD_W-1:0] IMM_MIN = -32'sd524288;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 8'd0,
      OP_SUB  = 8'd1,
      OP_MUL  = 8'd2,
      OP_AND  = 8'd3,
      OP_OR   = 8'd4,
      OP_XOR  = 8'd5,
      OP_SLL  = 8'd6,
      OP_SRA  = 8'd7,
      OP_SRL  = 8'd8,
      OP_BEQ  = 8'd9,
      OP_BNE  = 8'd10,
      OP_BLT  = 8'd11,
      OP_BGT  = 8'd12,
      OP_BLE  = 8'd13,
      OP_BGE  = 8'd14,
      OP_JAL  = 8'd15,
      OP_LW   = 8'd16,
      OP_SW   = 8'd17,
      OP_HALT = 8'd21
   } opcode_type;

   typedef enum logic [3:0] {
      CLS_NOP, CLS_ARITH, CLS_LOGIC, CLS_SHIFT, CLS_BRANCH,
      CLS_JAL, CLS_LOAD, CLS_STORE, CLS_HALT
   } class_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [IDX_W-1:0]  dest_index;
      logic [IDX_W-1:0]  src_a_index;
      logic [IDX_W-1:0]  src_b_index;
      logic [IMM_W-1:0]  immediate;
      logic [PC_W-1:0]   current_pc;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic              reg_written;
      logic [IDX_W-1:0]  write_index;
      logic [WORD_W-1:0] write_value;
      logic              halted;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      class_type         cls;
      logic [OP_W-1:0]   opcode;
      logic [IDX_W-1:0]  dest_index;
      logic [IDX_W-1:0]  src_a_index;
      logic [IDX_W-1:0]  src_b_index;
      logic [WORD_W-1:0] imm_ext;
      logic [PC_W-1:0]   seq_pc;
      logic              dest_ok;
   } uop_type;

   typedef enum logic [1:0] {
      EX_IDLE, EX_EXEC, EX_FINISH
   } ex_state_type;

endpackage

// ----- rtl/core/riex_if.sv -----
// ----------------------------------------------------------------------------
// riex_req_if / riex_rsp_if
// Valid-ready channels carrying instructions in and results out.
// ----------------------------------------------------------------------------
interface riex_req_if;
   import riex_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface riex_rsp_if;
   import riex_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/risc_instruction_execute_unit.sv -----
// An accepted instruction passes the front queue and the operand, result and output
// registers. The execute sequencer takes no new micro-op until it returns to idle;
// its steps are operand read and multiply, result and write back, and a hand-off to
// the output that can stall. A two-entry queue lets the front accept while the back
// is busy. Reset is synchronous: the register file clears at once, and the data
// memory is cleared over all MEM_DEPTH (4096) words before the first instruction runs.
// ----------------------------------------------------------------------------
// risc_instruction_execute_unit
// Top level: front classifier, micro-op queue and execute back end.
// ----------------------------------------------------------------------------
module risc_instruction_execute_unit (
   input logic        clock,
   input logic        reset,
   riex_req_if.sink   req,
   riex_rsp_if.source rsp
);
   import riex_pkg::*;

   logic    uop_valid, uop_ready;
   uop_type uop_payload;

   riex_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .req_payload (req.payload),
      .uop_valid   (uop_valid),
      .uop_ready   (uop_ready),
      .uop_payload (uop_payload)
   );

   riex_back u_back (
      .clock       (clock),
      .reset       (reset),
      .uop_valid   (uop_valid),
      .uop_ready   (uop_ready),
      .uop_payload (uop_payload),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .rsp_payload (rsp.payload)
   );

endmodule

// ----- rtl/core/riex_front.sv -----
// ----------------------------------------------------------------------------
// riex_front
// Accepts instructions, classifies them and queues micro-ops for execution.
// ----------------------------------------------------------------------------
module riex_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  riex_pkg::req_type req_payload,
   output logic              uop_valid,
   input  logic              uop_ready,
   output riex_pkg::uop_type uop_payload
);
   import riex_pkg::*;

   localparam int unsigned QDEPTH = 2;

   uop_type         q_ff [QDEPTH];
   logic            wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   uop_type         uop;
   logic            push, pop;
   logic [PC_W-1:0] len;

   always_comb begin
      uop = '0;
      case (req_payload.opcode) inside
         OP_ADD, OP_SUB, OP_MUL:         uop.cls = CLS_ARITH;
         OP_AND, OP_OR, OP_XOR:          uop.cls = CLS_LOGIC;
         OP_SLL, OP_SRA, OP_SRL:         uop.cls = CLS_SHIFT;
         [OP_BEQ:OP_BGE]:                uop.cls = CLS_BRANCH;
         OP_JAL:                         uop.cls = CLS_JAL;
         OP_LW:                          uop.cls = CLS_LOAD;
         OP_SW:                          uop.cls = CLS_STORE;
         OP_HALT:                        uop.cls = CLS_HALT;
         default:                        uop.cls = CLS_NOP;
      endcase
      len = (req_payload.dest_index == 4'd1 || req_payload.src_a_index == 4'd1 ||
             req_payload.src_b_index == 4'd1) ? 12'd2 : 12'd1;
      uop.opcode      = req_payload.opcode;
      uop.dest_index  = req_payload.dest_index;
      uop.src_a_index = req_payload.src_a_index;
      uop.src_b_index = req_payload.src_b_index;
      uop.imm_ext     = {{(WORD_W-IMM_W){req_payload.immediate[IMM_W-1]}},
                         req_payload.immediate};
      uop.seq_pc      = req_payload.current_pc + len;
      uop.dest_ok     = (req_payload.dest_index >= 4'd2);
   end

   assign req_ready   = (count_ff != 2'd2);
   assign push        = req_valid && req_ready;
   assign uop_valid   = (count_ff != 2'd0);
   assign pop         = uop_valid && uop_ready;
   assign uop_payload = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= uop;
      end
   end

endmodule

// ----- rtl/core/riex_back.sv -----
// ----------------------------------------------------------------------------
// riex_back
// Executes micro-ops against the register file and the data memory.
// ----------------------------------------------------------------------------
module riex_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              uop_valid,
   output logic              uop_ready,
   input  riex_pkg::uop_type uop_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output riex_pkg::rsp_type rsp_payload
);
   import riex_pkg::*;

   ex_state_type       state_ff, state_in;
   uop_type            u_ff;
   logic [WORD_W-1:0]  a_ff, b_ff, d_ff;
   logic [WORD_W-1:0]  rf_ff [16];
   logic [IMM_W-1:0]   mem [MEM_DEPTH];
   logic [IMM_W-1:0]   rdata_ff;
   logic               clearing_ff;
   logic [MEM_AW-1:0]  clr_addr_ff;
   logic signed [63:0] prod_ff;
   rsp_type            out_ff, res, held_ff;
   logic               out_valid_ff;
   logic               take, accept, finish, store;
   logic [WORD_W-1:0]  a, b, d, sum_ab;
   logic [MEM_AW-1:0]  addr;
   logic signed [33:0] exact_as;
   logic signed [63:0] exact;
   logic [4:0]         sh;

   function automatic logic [WORD_W-1:0] rd_reg(input logic [IDX_W-1:0] i,
      input logic [WORD_W-1:0] imm, input logic [WORD_W-1:0] v);
      if (i == 4'd0) return '0;
      if (i == 4'd1) return imm;
      return v;
   endfunction

   assign a = rd_reg(uop_payload.src_a_index, uop_payload.imm_ext,
                     rf_ff[uop_payload.src_a_index]);
   assign b = rd_reg(uop_payload.src_b_index, uop_payload.imm_ext,
                     rf_ff[uop_payload.src_b_index]);
   assign d = rd_reg(uop_payload.dest_index, uop_payload.imm_ext,
                     rf_ff[uop_payload.dest_index]);
   assign sum_ab = a + b;
   assign addr   = sum_ab[MEM_AW-1:0];

   assign uop_ready = (state_ff == EX_IDLE) && !clearing_ff;
   assign accept    = uop_valid && uop_ready;
   assign store     = accept && (uop_payload.cls == CLS_STORE);
   assign finish    = (state_ff == EX_FINISH) && (!out_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EX_IDLE:   if (accept) state_in = EX_EXEC;
         EX_EXEC:   state_in = EX_FINISH;
         EX_FINISH: if (finish) state_in = EX_IDLE;
         default:   state_in = EX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EX_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         u_ff    <= uop_payload;
         a_ff    <= a;
         b_ff    <= b;
         d_ff    <= d;
         prod_ff <= $signed(a) * $signed(b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == MEM_AW'(MEM_DEPTH - 1)) clearing_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (store) begin
         mem[addr] <= d[IMM_W-1:0];
      end
      rdata_ff <= mem[addr];
   end

   always_comb begin
      res             = '0;
      res.next_pc     = u_ff.seq_pc;
      take            = 1'b0;
      sh              = b_ff[4:0];
      exact_as        = (u_ff.opcode == OP_SUB) ?
                        {{2{a_ff[31]}}, a_ff} - {{2{b_ff[31]}}, b_ff} :
                        {{2{a_ff[31]}}, a_ff} + {{2{b_ff[31]}}, b_ff};
      exact           = (u_ff.opcode == OP_MUL) ? prod_ff : 64'(exact_as);
      res.write_value = '0;
      case (u_ff.cls)
         CLS_ARITH: begin
            if (u_ff.dest_ok) begin
               if (exact > 64'(IMM_MAX) || exact < 64'(IMM_MIN)) begin
                  res.overflow = 1'b1;
                  res.halted   = 1'b1;
               end else begin
                  res.reg_written = 1'b1;
                  res.write_value = exact[WORD_W-1:0];
               end
            end
         end
         CLS_LOGIC: begin
            res.reg_written = u_ff.dest_ok;
            case (u_ff.opcode)
               OP_AND:  res.write_value = a_ff & b_ff;
               OP_OR:   res.write_value = a_ff | b_ff;
               default: res.write_value = a_ff ^ b_ff;
            endcase
         end
         CLS_SHIFT: begin
            res.reg_written = u_ff.dest_ok;
            case (u_ff.opcode)
               OP_SLL:  res.write_value = a_ff << sh;
               OP_SRA:  res.write_value = $unsigned($signed(a_ff) >>> sh);
               default: res.write_value = a_ff >> sh;
            endcase
         end
         CLS_BRANCH: begin
            case (u_ff.opcode)
               OP_BEQ:  take = (a_ff == b_ff);
               OP_BNE:  take = (a_ff != b_ff);
               OP_BLT:  take = ($signed(a_ff) < $signed(b_ff));
               OP_BGT:  take = ($signed(a_ff) > $signed(b_ff));
               OP_BLE:  take = ($signed(a_ff) <= $signed(b_ff));
               default: take = ($signed(a_ff) >= $signed(b_ff));
            endcase
            if (take) res.next_pc = d_ff[PC_W-1:0];
         end
         CLS_JAL: begin
            res.reg_written = u_ff.dest_ok;
            res.write_value = {{(WORD_W-PC_W){1'b0}}, u_ff.seq_pc};
            res.next_pc     = a_ff[PC_W-1:0];
         end
         CLS_LOAD: begin
            res.reg_written = u_ff.dest_ok;
            res.write_value = {{(WORD_W-IMM_W){rdata_ff[IMM_W-1]}}, rdata_ff};
         end
         CLS_HALT: res.halted = 1'b1;
         default:  res.halted = 1'b0;
      endcase
      if (!res.reg_written) res.write_value = '0;
      res.write_index = res.reg_written ? u_ff.dest_index : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) rf_ff[i] <= '0;
      end else if (state_ff == EX_EXEC && res.reg_written) begin
         rf_ff[u_ff.dest_index] <= res.write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == EX_EXEC) out_ff <= res;
      else if (finish) out_ff <= out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) out_valid_ff <= 1'b0;
         if (finish) out_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) held_ff <= out_ff;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = held_ff;

endmodule

// ----- rtl/core/riex_checker.sv -----
// ----------------------------------------------------------------------------
// riex_checker
// Port-level checks on the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module riex_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input riex_pkg::rsp_type rsp_payload
);
   import riex_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overflow |-> rsp_payload.halted && !rsp_payload.reg_written)
      else $error("Overflow result must halt without a write.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.reg_written |-> rsp_payload.write_index >= 4'd2)
      else $error("Write reported to r0 or r1.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.reg_written |->
         rsp_payload.write_index == '0 && rsp_payload.write_value == '0)
      else $error("Write fields not cleared without a write.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result changed.");

endmodule

bind risc_instruction_execute_unit riex_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
